// ===== rtl/pwmppm_pkg.sv =====
// Package for the PWM pulse to ppm decoder.
// Widths, status codes, request types and sequencer states; no dependencies.
package pwmppm_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned FS_W    = 14;
  localparam int unsigned NUM_W   = TIME_W + FS_W;
  localparam int unsigned DEN_W   = TIME_W + 1;
  localparam int unsigned QUOT_W  = FS_W + 1;
  localparam int unsigned CNT_W   = $clog2(NUM_W + 1);

  localparam logic [FS_W-1:0]   FS_RESET    = FS_W'(5000);
  localparam logic [TIME_W-1:0] HIGH_OFFSET = TIME_W'(2);
  localparam logic [DEN_W-1:0]  DEN_OFFSET  = DEN_W'(4);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CLAMP = 2'd1;
  localparam logic [1:0] ST_DENOM = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] sample_time_ms;
    logic              pin_level;
  } in_req_t;

  typedef struct packed {
    logic [FS_W-1:0] ppm_value;
    logic [1:0]      status;
  } out_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_RESULT
  } state_e;

endpackage

// ===== rtl/pwmppm_edge.sv =====
// Edge tracker: stored level, rise/fall timestamps, low and high durations.
// Depends on pwmppm_pkg.
module pwmppm_edge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_valid_i,
  input  pwmppm_pkg::in_req_t           sample_i,
  output logic                          fall_o,
  output logic [pwmppm_pkg::TIME_W-1:0] high_o,
  output logic [pwmppm_pkg::TIME_W-1:0] low_o
);

  logic                          level_q;
  logic [pwmppm_pkg::TIME_W-1:0] rise_q;
  logic [pwmppm_pkg::TIME_W-1:0] fall_q;
  logic [pwmppm_pkg::TIME_W-1:0] low_q;
  logic [pwmppm_pkg::TIME_W-1:0] high_q;
  logic                          rise_evt;
  logic                          fall_evt;

  assign rise_evt = sample_valid_i && sample_i.pin_level && !level_q;
  assign fall_evt = sample_valid_i && !sample_i.pin_level && level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      rise_q  <= '0;
      fall_q  <= '0;
      low_q   <= '0;
    end else if (rise_evt) begin
      level_q <= 1'b1;
      rise_q  <= sample_i.sample_time_ms;
      low_q   <= sample_i.sample_time_ms - fall_q;
    end else if (fall_evt) begin
      level_q <= 1'b0;
      fall_q  <= sample_i.sample_time_ms;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fall_evt) begin
      high_q <= sample_i.sample_time_ms - rise_q;
    end
  end

  assign fall_o = fall_evt;
  assign high_o = high_q;
  assign low_o  = low_q;

endmodule

// ===== rtl/pwmppm_div.sv =====
// Restoring divider, one quotient bit per cycle through one shared subtractor.
// Quotient kept to QUOT_W bits with a sticky overflow flag. Depends on pwmppm_pkg.
module pwmppm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pwmppm_pkg::NUM_W-1:0] num_i,
  input  logic [pwmppm_pkg::DEN_W-1:0] den_i,
  output pwmppm_pkg::div_res_t         res_o
);

  logic [pwmppm_pkg::NUM_W-1:0]  num_q;
  logic [pwmppm_pkg::DEN_W-1:0]  rem_q;
  logic [pwmppm_pkg::QUOT_W-1:0] quot_q;
  logic                          ovf_q;
  logic [pwmppm_pkg::CNT_W-1:0]  cnt_q;
  logic                          busy_q;
  logic                          done_q;

  logic [pwmppm_pkg::DEN_W:0]    shifted;
  logic [pwmppm_pkg::DEN_W:0]    diff;
  logic                          ge;

  assign shifted = {rem_q, num_q[pwmppm_pkg::NUM_W-1]};
  assign diff    = shifted - {1'b0, den_i};
  assign ge      = shifted >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= pwmppm_pkg::CNT_W'(pwmppm_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - pwmppm_pkg::CNT_W'(1);
        if (cnt_q == pwmppm_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      num_q  <= {num_q[pwmppm_pkg::NUM_W-2:0], 1'b0};
      rem_q  <= ge ? diff[pwmppm_pkg::DEN_W-1:0] : shifted[pwmppm_pkg::DEN_W-1:0];
      quot_q <= {quot_q[pwmppm_pkg::QUOT_W-2:0], ge};
      ovf_q  <= ovf_q | quot_q[pwmppm_pkg::QUOT_W-1];
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quot = quot_q;

endmodule

// ===== rtl/pwm_pulse_to_ppm_decoder.sv =====
// PWM pulse to ppm decoder, top level: sequencer, scale multiply, output register.
// A rising edge or a repeated level is taken in the idle state; a falling edge runs
// through accept, check, multiply, the 46-step bit-serial divider and result; it skips
// from check straight to result when the denominator is not positive.
// A stalled result holds off the next request. Depends on pwmppm_pkg, _edge and _div.
// Reset (async, active low) clears level and timestamps, sets full scale to 5000.
module pwm_pulse_to_ppm_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pwmppm_pkg::in_req_t        in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pwmppm_pkg::out_req_t       out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pwmppm_pkg::FS_W-1:0] cfg_data_i
);

  pwmppm_pkg::state_e state_q, state_d;

  logic [pwmppm_pkg::FS_W-1:0]   fs_q;
  logic [pwmppm_pkg::DEN_W-1:0]  den_q;
  logic                          neg_q;
  pwmppm_pkg::out_req_t          res_q, res_d;
  pwmppm_pkg::out_req_t          out_q;
  logic                          out_valid_q;

  logic                          in_acc;
  logic                          fall;
  logic [pwmppm_pkg::TIME_W-1:0] high;
  logic [pwmppm_pkg::TIME_W-1:0] low;
  logic [pwmppm_pkg::DEN_W-1:0]  sum;
  logic                          den_bad;
  logic [pwmppm_pkg::TIME_W-1:0] factor;
  logic [pwmppm_pkg::NUM_W-1:0]  prod;
  logic                          div_start;
  logic                          load_out;
  logic                          check_en;
  pwmppm_pkg::div_res_t          div_res;

  assign in_acc = in_valid_i && in_ready_o;

  pwmppm_edge u_edge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (in_acc),
    .sample_i       (in_data_i),
    .fall_o         (fall),
    .high_o         (high),
    .low_o          (low)
  );

  pwmppm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (den_q),
    .res_o   (div_res)
  );

  assign sum     = {1'b0, high} + {1'b0, low};
  assign den_bad = sum <= pwmppm_pkg::DEN_OFFSET;
  assign factor  = neg_q ? (pwmppm_pkg::HIGH_OFFSET - high) : (high - pwmppm_pkg::HIGH_OFFSET);
  assign prod    = pwmppm_pkg::NUM_W'(fs_q) * pwmppm_pkg::NUM_W'(factor);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pwmppm_pkg::S_IDLE:   if (fall) state_d = pwmppm_pkg::S_CHECK;
      pwmppm_pkg::S_CHECK:  state_d = den_bad ? pwmppm_pkg::S_RESULT : pwmppm_pkg::S_MUL;
      pwmppm_pkg::S_MUL:    state_d = pwmppm_pkg::S_DIV;
      pwmppm_pkg::S_DIV:    if (div_res.done) state_d = pwmppm_pkg::S_RESULT;
      pwmppm_pkg::S_RESULT: if (load_out) state_d = pwmppm_pkg::S_IDLE;
      default:              state_d = pwmppm_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    check_en   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      pwmppm_pkg::S_IDLE:   in_ready_o = 1'b1;
      pwmppm_pkg::S_CHECK:  check_en = 1'b1;
      pwmppm_pkg::S_MUL:    div_start = 1'b1;
      pwmppm_pkg::S_DIV:    ;
      pwmppm_pkg::S_RESULT: load_out = !out_valid_q || out_ready_i;
      default:              ;
    endcase
  end

  // result selection
  always_comb begin
    res_d = res_q;
    if (check_en && den_bad) begin
      res_d.ppm_value = '0;
      res_d.status    = pwmppm_pkg::ST_DENOM;
    end else if (div_res.done) begin
      if (neg_q) begin
        res_d.ppm_value = '0;
        res_d.status    = (div_res.ovf || div_res.quot != '0) ?
                          pwmppm_pkg::ST_CLAMP : pwmppm_pkg::ST_OK;
      end else if (div_res.ovf || div_res.quot > {1'b0, fs_q}) begin
        res_d.ppm_value = fs_q;
        res_d.status    = pwmppm_pkg::ST_CLAMP;
      end else begin
        res_d.ppm_value = div_res.quot[pwmppm_pkg::FS_W-1:0];
        res_d.status    = pwmppm_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pwmppm_pkg::S_IDLE;
      fs_q        <= pwmppm_pkg::FS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        fs_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (check_en) begin
      den_q <= sum - pwmppm_pkg::DEN_OFFSET;
      neg_q <= high < pwmppm_pkg::HIGH_OFFSET;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ppm_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.ppm_value <= fs_q)
    else $error("ppm above full scale");

  a_denom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == pwmppm_pkg::ST_DENOM) |->
      out_data_o.ppm_value == '0)
    else $error("nonzero ppm with bad denominator");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == pwmppm_pkg::ST_OK ||
                     out_data_o.status == pwmppm_pkg::ST_CLAMP ||
                     out_data_o.status == pwmppm_pkg::ST_DENOM))
    else $error("undefined status code");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == pwmppm_pkg::S_DIV)
    else $error("divider finished outside divide state");

endmodule
